[hw/rtl/integer_to_ascii_formatter_defines.svh]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter assertion macros
// Macros for the concurrent checks of the formatter controller.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define ITAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define ITAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/itaf_pkg.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Cell control types, action codes and the fixed prefix texts.
// ----------------------------------------------------------------------------
package itaf_pkg;

  localparam int DigitW = 4;
  localparam int CharW  = 7;
  localparam int CountW = 5;
  localparam int ActW   = 2;
  localparam int PfxW   = 3;

  localparam logic [ActW-1:0] ActDec   = 2'd0;
  localparam logic [ActW-1:0] ActPtr   = 2'd1;
  localparam logic [ActW-1:0] ActHex32 = 2'd2;
  localparam logic [ActW-1:0] ActNone  = 2'd3;

  localparam logic [PfxW-1:0] PfxNone  = 3'd0;
  localparam logic [PfxW-1:0] PfxMinus = 3'd1;
  localparam logic [PfxW-1:0] PfxHex   = 3'd2;
  localparam logic [PfxW-1:0] PfxZero  = 3'd3;
  localparam logic [PfxW-1:0] PfxNil   = 3'd4;

  typedef enum logic [1:0] {
    CellHold,
    CellLoad,
    CellDabble,
    CellShift
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       carry0;
  } cell_ctrl_t;

  function automatic logic [2:0] prefix_len(input logic [PfxW-1:0] kind);
    logic [2:0] len;
    case (kind)
      PfxMinus: len = 3'd1;
      PfxHex:   len = 3'd2;
      PfxZero:  len = 3'd1;
      PfxNil:   len = 3'd5;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [CharW-1:0] prefix_char(input logic [PfxW-1:0] kind,
                                                   input logic [2:0] idx);
    logic [CharW-1:0] ch;
    ch = 7'h30;
    case (kind)
      PfxMinus: ch = 7'h2d;
      PfxHex:   ch = (idx == 3'd0) ? 7'h30 : 7'h78;
      PfxZero:  ch = 7'h30;
      PfxNil: begin
        case (idx)
          3'd0:    ch = 7'h28;
          3'd1:    ch = 7'h6e;
          3'd2:    ch = 7'h69;
          3'd3:    ch = 7'h6c;
          default: ch = 7'h29;
        endcase
      end
      default: ch = 7'h30;
    endcase
    return ch;
  endfunction

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d,
                                                  input logic upper);
    logic [CharW-1:0] ch;
    if (d < 4'd10) begin
      ch = 7'h30 + {3'b000, d};
    end else if (upper) begin
      ch = 7'h37 + {3'b000, d};
    end else begin
      ch = 7'h57 + {3'b000, d};
    end
    return ch;
  endfunction

endpackage

[hw/rtl/integer_to_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Prints a number as signed decimal, pointer hex or 32-bit hex, one ASCII
// character per output beat, most significant first.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                                   tuser / tlast
// s_axis   in   [63:0] value                            tuser [1:0] action, [2] letter_case
// m_axis   out  [6:0] character, [11:7] written_count   tlast = last_char
//
// Each item runs through the accept, the prefix beats, the double-dabble
// steps (nonzero decimal only), the leading-zero skip, which shifts out each
// leading zero cell, and the digit beats; zero and (nil) end after the prefix.
// The digit cells take one bit of the magnitude per cycle during conversion.
// Reset is asynchronous and active low; it empties the output register.
// A stalled output holds the prefix and digit steps in place; a new item is
// taken as soon as the last character of the previous one sits in the output
// register.
module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_CHARS  = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [63:0] value
  input  logic [2:0]  s_axis_tuser,  // [1:0] action, [2] letter_case
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [6:0] character, [11:7] written_count
  output logic        m_axis_tlast
);

  localparam int NumCells = (VALUE_BITS * 3) / 10 + 1;

  itaf_pkg::cell_ctrl_t                       cell_ctrl;
  logic [NumCells*itaf_pkg::DigitW-1:0]       load_nib;
  logic [itaf_pkg::DigitW-1:0]                cell_digit [NumCells];
  logic                                       cell_carry [NumCells];
  logic [itaf_pkg::CharW-1:0]                 out_char;
  logic [itaf_pkg::CountW-1:0]                out_count;

  itaf_ctrl #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_CHARS  (MAX_CHARS),
    .NumCells   (NumCells)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .action_i      (s_axis_tuser[1:0]),
    .value_i       (s_axis_tdata),
    .letter_case_i (s_axis_tuser[2]),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .char_o        (out_char),
    .last_o        (m_axis_tlast),
    .count_o       (out_count),
    .cell_ctrl_o   (cell_ctrl),
    .load_nib_o    (load_nib),
    .top_digit_i   (cell_digit[NumCells-1])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic [itaf_pkg::DigitW-1:0] prev_digit;
    logic                        prev_carry;
    if (i == 0) begin : g_first
      assign prev_digit = '0;
      assign prev_carry = cell_ctrl.carry0;
    end else begin : g_rest
      assign prev_digit = cell_digit[i-1];
      assign prev_carry = cell_carry[i-1];
    end
    itaf_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .load_digit_i (load_nib[i*itaf_pkg::DigitW +: itaf_pkg::DigitW]),
      .prev_digit_i (prev_digit),
      .prev_carry_i (prev_carry),
      .digit_o      (cell_digit[i]),
      .carry_o      (cell_carry[i])
    );
  end

  assign m_axis_tdata = {4'd0, out_count, out_char};

endmodule

[hw/rtl/itaf_cell.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter digit cell
// Holds one digit; loads it, runs one double-dabble step or takes the
// neighbor's digit.
// ----------------------------------------------------------------------------
module itaf_cell (
  input  logic                        clk_i,
  input  itaf_pkg::cell_ctrl_t        ctrl_i,
  input  logic [itaf_pkg::DigitW-1:0] load_digit_i,
  input  logic [itaf_pkg::DigitW-1:0] prev_digit_i,
  input  logic                        prev_carry_i,
  output logic [itaf_pkg::DigitW-1:0] digit_o,
  output logic                        carry_o
);

  logic [itaf_pkg::DigitW-1:0] digit_q, digit_d, adj;

  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    case (ctrl_i.mode)
      itaf_pkg::CellLoad:   digit_d = load_digit_i;
      itaf_pkg::CellDabble: digit_d = {adj[2:0], prev_carry_i};
      itaf_pkg::CellShift:  digit_d = prev_digit_i;
      default:              digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

[hw/rtl/itaf_ctrl.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter controller
// Sequences prefix, conversion, leading-zero skip and digit output, and
// holds the output register.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_defines.svh"

module itaf_ctrl #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_CHARS  = 20,
  parameter int NumCells   = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_valid_i,
  output logic                               s_ready_o,
  input  logic [itaf_pkg::ActW-1:0]          action_i,
  input  logic [63:0]                        value_i,
  input  logic                               letter_case_i,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic [itaf_pkg::CharW-1:0]         char_o,
  output logic                               last_o,
  output logic [itaf_pkg::CountW-1:0]        count_o,
  output itaf_pkg::cell_ctrl_t               cell_ctrl_o,
  output logic [NumCells*itaf_pkg::DigitW-1:0] load_nib_o,
  input  logic [itaf_pkg::DigitW-1:0]        top_digit_i
);

  localparam int BitW    = $clog2(VALUE_BITS + 1);
  localparam int RemW    = $clog2(NumCells + 1);
  localparam int LoadW   = NumCells * itaf_pkg::DigitW;
  localparam logic [63:0] ValueMask = {64{1'b1}} >> (64 - VALUE_BITS);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StPrefix = 3'd1;
  localparam logic [2:0] StConv   = 3'd2;
  localparam logic [2:0] StSkip   = 3'd3;
  localparam logic [2:0] StDigits = 3'd4;

  logic [2:0]                     state_q, state_d;
  logic [itaf_pkg::PfxW-1:0]      pfx_q, pfx_d;
  logic [2:0]                     pidx_q, pidx_d;
  logic                           upper_q, upper_d;
  logic [VALUE_BITS-1:0]          mag_q, mag_d;
  logic [BitW-1:0]                bits_q, bits_d;
  logic [RemW-1:0]                rem_q, rem_d;
  logic [itaf_pkg::CountW-1:0]    count_q, count_d;

  logic                           out_valid_q;
  logic [itaf_pkg::CharW-1:0]     out_char_q;
  logic                           out_last_q;
  logic [itaf_pkg::CountW-1:0]    out_count_q;

  logic                           s_fire, out_ok, trunc;
  logic                           emit, emit_last;
  logic [itaf_pkg::CharW-1:0]     emit_char;
  logic [VALUE_BITS-1:0]          dec_val, dec_mag;
  logic [63:0]                    hex_src, ptr_val;
  logic [2:0]                     plen;
  logic                           pfx_final;

  assign s_ready_o = (state_q == StIdle);
  assign s_fire    = s_valid_i && s_ready_o;
  assign out_ok    = !out_valid_q || m_ready_i;
  assign trunc     = (count_q == itaf_pkg::CountW'(MAX_CHARS - 1));

  assign dec_val = value_i[VALUE_BITS-1:0];
  assign dec_mag = dec_val[VALUE_BITS-1] ? (~dec_val + 1'b1) : dec_val;
  assign ptr_val = value_i & ValueMask;

  always_comb begin
    case (action_i)
      itaf_pkg::ActPtr:   hex_src = ptr_val;
      itaf_pkg::ActHex32: hex_src = {32'd0, value_i[31:0]};
      default:            hex_src = 64'd0;
    endcase
  end

  assign load_nib_o = LoadW'(hex_src);
  assign plen       = itaf_pkg::prefix_len(pfx_q);
  assign pfx_final  = (pfx_q == itaf_pkg::PfxZero) || (pfx_q == itaf_pkg::PfxNil);

  always_comb begin
    state_d            = state_q;
    pfx_d              = pfx_q;
    pidx_d             = pidx_q;
    upper_d            = upper_q;
    mag_d              = mag_q;
    bits_d             = bits_q;
    rem_d              = rem_q;
    count_d            = count_q;
    emit               = 1'b0;
    emit_last          = 1'b0;
    emit_char          = itaf_pkg::digit_char(top_digit_i, upper_q);
    cell_ctrl_o.mode   = itaf_pkg::CellHold;
    cell_ctrl_o.carry0 = mag_q[VALUE_BITS-1];

    case (state_q)
      StIdle: begin
        if (s_fire) begin
          pidx_d           = 3'd0;
          rem_d            = RemW'(NumCells);
          count_d          = '0;
          upper_d          = (action_i == itaf_pkg::ActHex32) && !letter_case_i;
          mag_d            = dec_mag;
          bits_d           = BitW'(VALUE_BITS);
          cell_ctrl_o.mode = itaf_pkg::CellLoad;
          case (action_i)
            itaf_pkg::ActDec: begin
              if (dec_val == '0) begin
                pfx_d   = itaf_pkg::PfxZero;
                state_d = StPrefix;
              end else if (dec_val[VALUE_BITS-1]) begin
                pfx_d   = itaf_pkg::PfxMinus;
                state_d = StPrefix;
              end else begin
                pfx_d   = itaf_pkg::PfxNone;
                state_d = StConv;
              end
            end
            itaf_pkg::ActPtr: begin
              pfx_d   = (ptr_val == 64'd0) ? itaf_pkg::PfxNil : itaf_pkg::PfxHex;
              state_d = StPrefix;
            end
            itaf_pkg::ActHex32: begin
              if (value_i[31:0] == 32'd0) begin
                pfx_d   = itaf_pkg::PfxZero;
                state_d = StPrefix;
              end else begin
                pfx_d   = itaf_pkg::PfxNone;
                state_d = StSkip;
              end
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StPrefix: begin
        if (out_ok) begin
          emit      = 1'b1;
          emit_char = itaf_pkg::prefix_char(pfx_q, pidx_q);
          emit_last = (pfx_final && (pidx_q == plen - 3'd1)) || trunc;
          count_d   = count_q + 1'b1;
          pidx_d    = pidx_q + 3'd1;
          if (emit_last) begin
            state_d = StIdle;
          end else if (pidx_q == plen - 3'd1) begin
            state_d = (pfx_q == itaf_pkg::PfxMinus) ? StConv : StSkip;
          end
        end
      end
      StConv: begin
        cell_ctrl_o.mode = itaf_pkg::CellDabble;
        mag_d            = mag_q << 1;
        bits_d           = bits_q - 1'b1;
        if (bits_q == BitW'(1)) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if ((top_digit_i == 4'd0) && (rem_q > RemW'(1))) begin
          cell_ctrl_o.mode = itaf_pkg::CellShift;
          rem_d            = rem_q - 1'b1;
        end else begin
          state_d = StDigits;
        end
      end
      StDigits: begin
        if (out_ok) begin
          emit             = 1'b1;
          emit_last        = (rem_q == RemW'(1)) || trunc;
          count_d          = count_q + 1'b1;
          cell_ctrl_o.mode = itaf_pkg::CellShift;
          rem_d            = rem_q - 1'b1;
          if (emit_last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pfx_q   <= pfx_d;
    pidx_q  <= pidx_d;
    upper_q <= upper_d;
    mag_q   <= mag_d;
    bits_q  <= bits_d;
    rem_q   <= rem_d;
    count_q <= count_d;
    if (emit) begin
      out_char_q  <= emit_char;
      out_last_q  <= emit_last;
      out_count_q <= count_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign char_o    = out_char_q;
  assign last_o    = out_last_q;
  assign count_o   = out_count_q;

  `ITAF_ASSERT_NOW(a_count_range, out_valid_q, (out_count_q != '0) && (out_count_q <= itaf_pkg::CountW'(MAX_CHARS)), "Output count out of range.")
  `ITAF_ASSERT_NOW(a_skip_finds_digit, (state_q == StSkip) && (rem_q == RemW'(1)), top_digit_i != 4'd0, "Leading-zero skip ran past all digits.")
  `ITAF_ASSERT_NOW(a_first_digit_nonzero, (state_q == StDigits) && ($past(state_q) == StSkip), top_digit_i != 4'd0, "First emitted digit is a leading zero.")
  `ITAF_ASSERT_NEXT(a_accept_starts_work, s_fire && (action_i != itaf_pkg::ActNone), state_q != StIdle, "Accepted item did not start work.")

endmodule

[tb/integer_to_ascii_formatter_test.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter testbench
// Feeds numbers with all three print formats and the unused action code. It
// first sends edge values, then random ones, with bursty input and a stalling
// output. A scoreboard builds the text that each number must print and checks
// every output beat against it, character by character.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ValueBits = 64;
  localparam int MaxChars  = 20;
  localparam int NumItems  = 210;
  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 150;

  localparam logic [127:0] HexLower = "0123456789abcdef";
  localparam logic [127:0] HexUpper = "0123456789ABCDEF";
  localparam logic [39:0]  NilText  = "(nil)";

  typedef struct packed {
    logic [itaf_pkg::CharW-1:0]  code;
    logic                        last;
    logic [itaf_pkg::CountW-1:0] count;
  } char_beat_t;

  class char_board;
    char_beat_t pending[$];
    int mismatches;
    int chars_checked;
    int numbers_by_action[4];

    function void put_digits(ref logic [itaf_pkg::CharW-1:0] text[$],
                             input logic [63:0] mag,
                             input int base, input logic [127:0] digits);
      logic [itaf_pkg::CharW-1:0] rev[$];
      int d;
      while (mag != 0) begin
        d = int'(mag % 64'(base));
        rev.push_front(digits[8*(15-d) +: itaf_pkg::CharW]);
        mag = mag / 64'(base);
      end
      foreach (rev[i]) text.push_back(rev[i]);
    endfunction

    function void note_number(logic [itaf_pkg::ActW-1:0] action, logic [63:0] value,
                              logic lc);
      logic [itaf_pkg::CharW-1:0] text[$];
      logic [63:0] vmask;
      logic [63:0] mag;
      char_beat_t beat;
      int len;
      vmask = {64{1'b1}} >> (64 - ValueBits);
      numbers_by_action[action]++;
      case (action)
        itaf_pkg::ActDec: begin
          mag = value & vmask;
          if (mag[ValueBits-1]) begin
            text.push_back(7'h2d);
            mag = (64'd0 - mag) & vmask;
          end
          if (mag == 0) text.push_back(7'h30);
          else put_digits(text, mag, 10, HexLower);
        end
        itaf_pkg::ActPtr: begin
          mag = value & vmask;
          if (mag == 0) begin
            for (int i = 0; i < 5; i++) text.push_back(NilText[8*(4-i) +: itaf_pkg::CharW]);
          end else begin
            text.push_back(7'h30);
            text.push_back(7'h78);
            put_digits(text, mag, 16, HexLower);
          end
        end
        itaf_pkg::ActHex32: begin
          mag = {32'd0, value[31:0]};
          if (mag == 0) text.push_back(7'h30);
          else put_digits(text, mag, 16, lc ? HexLower : HexUpper);
        end
        default: ;
      endcase
      len = (text.size() > MaxChars) ? MaxChars : text.size();
      for (int i = 0; i < len; i++) begin
        beat.code  = text[i];
        beat.last  = (i == len - 1);
        beat.count = itaf_pkg::CountW'(i + 1);
        pending.push_back(beat);
      end
    endfunction

    function void report(string what, char_beat_t exp_beat, char_beat_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected char %h last %b count %0d, got char %h last %b count %0d",
                 what, exp_beat.code, exp_beat.last, exp_beat.count,
                 got.code, got.last, got.count);
      end
    endfunction

    function void check_char(logic [itaf_pkg::CharW-1:0] code, logic last,
                             logic [itaf_pkg::CountW-1:0] count);
      char_beat_t got;
      char_beat_t exp_beat;
      got = '{code: code, last: last, count: count};
      chars_checked++;
      if (pending.size() == 0) begin
        report("Unexpected beat", '0, got);
      end else begin
        exp_beat = pending.pop_front();
        if (got != exp_beat) report("Mismatch", exp_beat, got);
      end
    endfunction

    function void check_leftover();
      if (pending.size() != 0) begin
        mismatches++;
        $display("%0d expected characters never arrived", pending.size());
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  char_board board;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_mode_left = 0;
  int idle_cycles = 0;
  int sent_count = 0;

  integer_to_ascii_formatter #(
    .VALUE_BITS(ValueBits),
    .MAX_CHARS (MaxChars)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_number(logic [itaf_pkg::ActW-1:0] action, logic [63:0] value,
                             logic lc);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= {lc, action};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_number(action, value, lc);
    sent_count++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    logic [63:0] p;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      1: v = 64'($urandom_range(0, 20));
      2: v = 64'd0 - 64'($urandom_range(1, 20));
      3: begin
        p = 64'd1;
        repeat ($urandom_range(0, 19)) p = p * 64'd10;
        v = p + 64'($urandom_range(0, 2)) - 64'd1;
        if ($urandom_range(0, 1) == 1) v = 64'd0 - v;
      end
      4: v = v & ({64{1'b1}} >> $urandom_range(0, 63));
      5: begin
        case ($urandom_range(0, 3))
          0: v = 64'd0;
          1: v = 64'h8000_0000_0000_0000;
          2: v = 64'h7fff_ffff_ffff_ffff;
          default: v = {64{1'b1}};
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_char(m_axis_tdata[6:0], m_axis_tlast, m_axis_tdata[11:7]);
    end
    if (stall_mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_mode_left = $urandom_range(10, 80);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      default: m_axis_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no beat moved for %0d cycles", IdleLimit);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [itaf_pkg::ActW-1:0] action;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_number(itaf_pkg::ActDec, 64'd0, 1'b0);
    send_number(itaf_pkg::ActDec, 64'd1, 1'b1);
    send_number(itaf_pkg::ActDec, {64{1'b1}}, 1'b0);
    send_number(itaf_pkg::ActDec, 64'h8000_0000_0000_0000, 1'b0);
    send_number(itaf_pkg::ActDec, 64'h7fff_ffff_ffff_ffff, 1'b1);
    send_number(itaf_pkg::ActDec, 64'd999999999999999999, 1'b0);
    send_number(itaf_pkg::ActDec, 64'd1000000000000000000, 1'b0);
    send_number(itaf_pkg::ActDec, 64'd0 - 64'd1000000000000000000, 1'b0);
    send_number(itaf_pkg::ActDec, 64'd10000000000000000000, 1'b0);
    send_number(itaf_pkg::ActDec, 64'd9, 1'b0);
    send_number(itaf_pkg::ActPtr, 64'd0, 1'b1);
    send_number(itaf_pkg::ActPtr, 64'd1, 1'b0);
    send_number(itaf_pkg::ActPtr, {64{1'b1}}, 1'b1);
    send_number(itaf_pkg::ActPtr, 64'h0123_4567_89ab_cdef, 1'b0);
    send_number(itaf_pkg::ActHex32, 64'd0, 1'b0);
    send_number(itaf_pkg::ActHex32, 64'h0000_0000_ffff_ffff, 1'b0);
    send_number(itaf_pkg::ActHex32, 64'h0000_0000_ffff_ffff, 1'b1);
    send_number(itaf_pkg::ActHex32, 64'hffff_ffff_0000_0000, 1'b1);
    send_number(itaf_pkg::ActHex32, 64'h1234_5678_abcd_ef12, 1'b0);
    send_number(itaf_pkg::ActHex32, 64'h0000_0000_0000_0001, 1'b1);
    send_number(itaf_pkg::ActNone, {64{1'b1}}, 1'b1);
    send_number(itaf_pkg::ActNone, 64'd0, 1'b0);
    send_number(itaf_pkg::ActDec, 64'd10, 1'b0);

    while (sent_count < NumItems) begin
      action = ($urandom_range(0, 19) == 0) ? itaf_pkg::ActNone :
                                              itaf_pkg::ActW'($urandom_range(0, 2));
      send_number(action, pick_value(), 1'($urandom_range(0, 1)));
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    board.check_leftover();

    $display("Sent %0d decimal, %0d pointer, %0d 32-bit hex and %0d unused-action numbers.",
             board.numbers_by_action[0], board.numbers_by_action[1],
             board.numbers_by_action[2], board.numbers_by_action[3]);
    $display("Checked %0d output characters, %0d mismatches.",
             board.chars_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
